// File: rtl/binary_trie_longest_prefix_match_top_defines.svh
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_TOP_DEFINES_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_TOP_DEFINES_SVH

// checked only out of reset
`define BTLPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define BTLPM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/btlpm_pkg.sv
`timescale 1ns / 1ps

package btlpm_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DESCEND,
    ACT_ALLOC,
    ACT_MARK,
    ACT_FULL,
    ACT_LK_DONE,
    ACT_PUSH
  } action_e;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_UPDATED = 3'd1,
    ST_FULL    = 3'd2,
    ST_HIT     = 3'd3,
    ST_MISS    = 3'd4
  } status_e;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic is_lookup;
    logic at_end;
    logic nxt_zero;
    logic store_full;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/binary_trie_longest_prefix_match_top.sv
`timescale 1ns / 1ps

// channel  handshake               payload
// in       in_valid_i / in_stall_o kind_i, address_i, prefix_length_i, port_i
// out      out_valid_o/ out_stall_i status_o, port_out_o
//
// one item at a time: an accept step, one walk step per trie level (a descend reads
// the node store, an alloc makes a node), a finish step and a result step that waits
// on a stalled output; an insert walks the clamped prefix_length, a lookup its path
// reset clears the root, the free-node counter and the output valid flag, no sweep
// the next item is taken while a result still waits in the output register

module binary_trie_longest_prefix_match_top #(
  parameter int unsigned NODE_COUNT   = 65536,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] address_i,
  input  logic [5:0]  prefix_length_i,
  input  logic [7:0]  port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  port_out_o
);
  import btlpm_pkg::*;

  action_e    act;
  dp_status_t stat;

  btlpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .act_o      (act)
  );

  btlpm_datapath #(
    .NODE_COUNT   (NODE_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .act_i           (act),
    .kind_i          (kind_i),
    .address_i       (address_i),
    .prefix_length_i (prefix_length_i),
    .port_i          (port_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .port_out_o      (port_out_o),
    .stat_o          (stat)
  );

endmodule

// File: rtl/btlpm_ctrl.sv
`timescale 1ns / 1ps

module btlpm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  btlpm_pkg::dp_status_t  stat_i,
  output btlpm_pkg::action_e     act_o
);
  import btlpm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    act_o      = ACT_NONE;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_o   = ACT_LOAD;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.is_lookup) begin
          if (stat_i.at_end || stat_i.nxt_zero) begin
            act_o   = ACT_LK_DONE;
            state_d = S_DONE;
          end else begin
            act_o = ACT_DESCEND;
          end
        end else begin
          priority if (stat_i.at_end) begin
            act_o   = ACT_MARK;
            state_d = S_DONE;
          end else if (!stat_i.nxt_zero) begin
            act_o = ACT_DESCEND;
          end else if (stat_i.store_full) begin
            act_o   = ACT_FULL;
            state_d = S_DONE;
          end else begin
            act_o = ACT_ALLOC;
          end
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          act_o   = ACT_PUSH;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/btlpm_datapath.sv
`timescale 1ns / 1ps

module btlpm_datapath #(
  parameter int unsigned NODE_COUNT   = 65536,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btlpm_pkg::action_e    act_i,
  input  logic                  kind_i,
  input  logic [31:0]           address_i,
  input  logic [5:0]            prefix_length_i,
  input  logic [7:0]            port_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [2:0]            status_o,
  output logic [7:0]            port_out_o,
  output btlpm_pkg::dp_status_t stat_o
);
  import btlpm_pkg::*;

  localparam int unsigned IDX_W = $clog2(NODE_COUNT);
  localparam int unsigned LVL_W = $clog2(ADDRESS_BITS + 1);
  localparam int unsigned ENT_W = 2 * IDX_W + 9;
  localparam logic [IDX_W:0]   NODE_LIMIT = NODE_COUNT[IDX_W:0];
  localparam logic [LVL_W-1:0] ADDR_LIMIT = ADDRESS_BITS[LVL_W-1:0];
  localparam logic [5:0]       PLEN_MAX   = ADDRESS_BITS[5:0];

  // node store, entry is {left, right, match, port}; node 0 lives in flops
  logic [ENT_W-1:0] mem_q [NODE_COUNT];
  logic [ENT_W-1:0] rd_q;
  logic             use_rd_q;

  logic [IDX_W-1:0] root_left_q, root_right_q;
  logic             root_match_q;
  logic [7:0]       root_port_q;

  logic [IDX_W-1:0] cur_idx_q, cur_left_q, cur_right_q;
  logic             cur_match_q;
  logic [7:0]       cur_port_q;

  logic [ADDRESS_BITS-1:0] addr_q;
  logic [LVL_W-1:0]        level_q, limit_q, limit_d;
  logic                    kind_q, added_q, hit_q;
  logic [7:0]              port_q, best_q;
  logic [IDX_W:0]          next_free_q;
  status_e                 res_status_q;
  logic [7:0]              res_port_q;
  logic                    out_valid_q;
  logic [2:0]              out_status_q;
  logic [7:0]              out_port_q;

  logic [IDX_W-1:0] eff_left, eff_right, nxt, wr_left, wr_right;
  logic             eff_match, wr_match, walk_bit, wr_en, to_root;
  logic [7:0]       eff_port, wr_port;

  // current node comes straight from the read register right after a descend
  always_comb begin
    if (use_rd_q) begin
      eff_left  = rd_q[ENT_W-1 -: IDX_W];
      eff_right = rd_q[IDX_W+8 -: IDX_W];
      eff_match = rd_q[8];
      eff_port  = rd_q[7:0];
    end else begin
      eff_left  = cur_left_q;
      eff_right = cur_right_q;
      eff_match = cur_match_q;
      eff_port  = cur_port_q;
    end
  end

  assign walk_bit = addr_q[ADDRESS_BITS-1];
  assign nxt      = walk_bit ? eff_right : eff_left;
  assign to_root  = (cur_idx_q == '0);
  assign wr_en    = (act_i == ACT_ALLOC) || (act_i == ACT_MARK) || (act_i == ACT_FULL);

  always_comb begin
    wr_left  = eff_left;
    wr_right = eff_right;
    wr_match = eff_match;
    wr_port  = eff_port;
    if (act_i == ACT_ALLOC) begin
      if (walk_bit) begin
        wr_right = next_free_q[IDX_W-1:0];
      end else begin
        wr_left = next_free_q[IDX_W-1:0];
      end
    end
    if (act_i == ACT_MARK) begin
      wr_match = 1'b1;
      wr_port  = port_q;
    end
  end

  assign limit_d = (kind_i == KIND_LOOKUP) ? ADDR_LIMIT :
                   (prefix_length_i > PLEN_MAX) ? ADDR_LIMIT :
                   prefix_length_i[LVL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en && !to_root) begin
      mem_q[cur_idx_q] <= {wr_left, wr_right, wr_match, wr_port};
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i == ACT_DESCEND) begin
      rd_q <= mem_q[nxt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_left_q  <= '0;
      root_right_q <= '0;
      root_match_q <= 1'b0;
      root_port_q  <= '0;
      use_rd_q     <= 1'b0;
      next_free_q  <= {{IDX_W{1'b0}}, 1'b1};
      out_valid_q  <= 1'b0;
    end else begin
      if (wr_en && to_root) begin
        root_left_q  <= wr_left;
        root_right_q <= wr_right;
        root_match_q <= wr_match;
        root_port_q  <= wr_port;
      end
      if (act_i == ACT_LOAD || act_i == ACT_ALLOC) begin
        use_rd_q <= 1'b0;
      end else if (act_i == ACT_DESCEND) begin
        use_rd_q <= 1'b1;
      end
      if (act_i == ACT_ALLOC) begin
        next_free_q <= next_free_q + {{IDX_W{1'b0}}, 1'b1};
      end
      if (act_i == ACT_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (act_i)
      ACT_LOAD: begin
        addr_q      <= address_i[ADDRESS_BITS-1:0];
        kind_q      <= kind_i;
        port_q      <= port_i;
        level_q     <= '0;
        limit_q     <= limit_d;
        cur_idx_q   <= '0;
        cur_left_q  <= root_left_q;
        cur_right_q <= root_right_q;
        cur_match_q <= root_match_q;
        cur_port_q  <= root_port_q;
        added_q     <= 1'b0;
        hit_q       <= 1'b0;
        best_q      <= '0;
      end
      ACT_DESCEND: begin
        addr_q    <= addr_q << 1;
        level_q   <= level_q + {{(LVL_W-1){1'b0}}, 1'b1};
        cur_idx_q <= nxt;
        if (eff_match) begin
          hit_q  <= 1'b1;
          best_q <= eff_port;
        end
      end
      ACT_ALLOC: begin
        addr_q      <= addr_q << 1;
        level_q     <= level_q + {{(LVL_W-1){1'b0}}, 1'b1};
        cur_idx_q   <= next_free_q[IDX_W-1:0];
        cur_left_q  <= '0;
        cur_right_q <= '0;
        cur_match_q <= 1'b0;
        cur_port_q  <= '0;
        added_q     <= 1'b1;
      end
      ACT_MARK: begin
        res_status_q <= added_q ? ST_NEW : ST_UPDATED;
        res_port_q   <= '0;
      end
      ACT_FULL: begin
        res_status_q <= ST_FULL;
        res_port_q   <= '0;
      end
      ACT_LK_DONE: begin
        // deepest marked node wins, the current one included
        if (hit_q || eff_match) begin
          res_status_q <= ST_HIT;
          res_port_q   <= eff_match ? eff_port : best_q;
        end else begin
          res_status_q <= ST_MISS;
          res_port_q   <= '0;
        end
      end
      ACT_PUSH: begin
        out_status_q <= res_status_q;
        out_port_q   <= res_port_q;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.is_lookup  = (kind_q == KIND_LOOKUP);
  assign stat_o.at_end     = (level_q == limit_q);
  assign stat_o.nxt_zero   = (nxt == '0);
  assign stat_o.store_full = (next_free_q == NODE_LIMIT);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign port_out_o  = out_port_q;

endmodule

// File: rtl/btlpm_checker.sv
`timescale 1ns / 1ps

`include "binary_trie_longest_prefix_match_top_defines.svh"

module btlpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_i,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [2:0] status_i,
  input logic [7:0] port_out_i
);
  import btlpm_pkg::*;

  // a stalled result holds
  `BTLPM_ASSERT(a_out_hold, out_valid_i && out_stall_i |=> out_valid_i && $stable(status_i) && $stable(port_out_i), "stalled result changed")

  // only a hit carries a port
  `BTLPM_ASSERT(a_port_zero, out_valid_i && status_i != ST_HIT |-> port_out_i == 8'd0, "port on a non-hit result")

  // one item at a time: after a transfer in, the input is stalled
  `BTLPM_ASSERT(a_busy_after_in, in_valid_i && !in_stall_i |=> in_stall_i, "second item taken while busy")

  // a new result appears only out of a walk in progress
  `BTLPM_ASSERT(a_result_from_walk, $rose(out_valid_i) |-> $past(in_stall_i), "result without an item")

  // an edge in reset clears the output register by the next edge
  `BTLPM_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_i, "result valid in reset")

endmodule

bind binary_trie_longest_prefix_match_top btlpm_checker u_btlpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_i    (status_o),
  .port_out_i  (port_out_o)
);

// File: tb/binary_trie_longest_prefix_match_top_tb.sv
`timescale 1ns / 1ps

module binary_trie_longest_prefix_match_top_tb;
  import btlpm_pkg::*;

  localparam int unsigned TRIE_NODES  = 65536;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 600;

  typedef struct packed {
    status_e    status;
    logic [7:0] port;
  } answer_t;

  typedef struct packed {
    logic       kind;
    logic [31:0] addr;
    logic [5:0] plen;
    logic [7:0] port;
    logic       fixed;
    answer_t    want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [31:0] address_i = '0;
  logic [5:0]  prefix_length_i = '0;
  logic [7:0]  port_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  port_out_o;

  // shadow trie
  int unsigned trie_left [TRIE_NODES];
  int unsigned trie_right[TRIE_NODES];
  bit          trie_marked[TRIE_NODES];
  logic [7:0]  trie_port [TRIE_NODES];
  int unsigned free_node = 1;

  answer_t     pending_answers[$];
  logic [31:0] known_addr[$];
  logic [5:0]  known_len[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_calm_left = 0;
  int unsigned rx_calm_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_pick;
  bit          hold_req = 1'b0;
  answer_t     seen_want;

  binary_trie_longest_prefix_match_top #(
    .NODE_COUNT  (TRIE_NODES),
    .ADDRESS_BITS(ADDR_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .address_i      (address_i),
    .prefix_length_i(prefix_length_i),
    .port_i         (port_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .port_out_o     (port_out_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_answers.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // walks the shadow trie for one item, updating it on inserts
  function automatic answer_t trie_answer(input logic kind, input logic [31:0] addr,
                                          input logic [5:0] plen, input logic [7:0] port);
    answer_t     ans;
    int unsigned depth;
    int unsigned cur;
    int unsigned nxt;
    int unsigned lvl;
    bit          grew;
    bit          bitv;
    ans.status = ST_MISS;
    ans.port = '0;
    cur = 0;
    grew = 1'b0;
    if (kind == KIND_INSERT) begin
      depth = (plen > ADDR_BITS) ? ADDR_BITS : plen;
      for (lvl = 0; lvl < depth; lvl++) begin
        bitv = addr[ADDR_BITS - 1 - lvl];
        nxt = bitv ? trie_right[cur] : trie_left[cur];
        if (nxt == 0) begin
          // out of nodes: nodes made so far stay, nothing is marked
          if (free_node >= TRIE_NODES) begin
            ans.status = ST_FULL;
            return ans;
          end
          nxt = free_node;
          free_node++;
          trie_left[nxt] = 0;
          trie_right[nxt] = 0;
          trie_marked[nxt] = 1'b0;
          trie_port[nxt] = '0;
          if (bitv) trie_right[cur] = nxt;
          else trie_left[cur] = nxt;
          grew = 1'b1;
        end
        cur = nxt;
      end
      trie_marked[cur] = 1'b1;
      trie_port[cur] = port;
      if (grew) ans.status = ST_NEW;
      else ans.status = ST_UPDATED;
    end else begin
      if (trie_marked[0]) begin
        ans.status = ST_HIT;
        ans.port = trie_port[0];
      end
      for (lvl = 0; lvl < ADDR_BITS; lvl++) begin
        nxt = addr[ADDR_BITS - 1 - lvl] ? trie_right[cur] : trie_left[cur];
        if (nxt == 0) break;
        cur = nxt;
        if (trie_marked[cur]) begin
          ans.status = ST_HIT;
          ans.port = trie_port[cur];
        end
      end
    end
    return ans;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (tx_calm_left != 0) begin
      tx_calm_left--;
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 3) tx_calm_left = $urandom_range(40, 10);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // returns right after the transfer edge with the item still on the bus
  task automatic send_route(input logic kind, input logic [31:0] addr, input logic [5:0] plen,
                            input logic [7:0] port, input logic fixed, input answer_t want);
    int unsigned gap;
    answer_t     ans;
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = kind;
    address_i = addr;
    prefix_length_i = plen;
    port_i = port;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ans = trie_answer(kind, addr, plen, port);
    if (fixed) pending_answers.push_back(want);
    else pending_answers.push_back(ans);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned lp;
    int unsigned idx;
    int unsigned depth;
    logic [31:0] a;
    logic [31:0] below;
    logic [5:0]  len;
    pick = $urandom_range(99);
    if (known_addr.size() == 0) pick = 0;
    if (pick < 35) begin
      lp = $urandom_range(99);
      if (lp < 5) len = '0;
      else if (lp < 15) len = 6'($urandom_range(63, 33));
      else if (lp < 30) len = 6'($urandom_range(7, 1));
      else len = 6'($urandom_range(32, 8));
      a = $urandom;
      known_addr.push_back(a);
      known_len.push_back(len);
      send_route(KIND_INSERT, a, len, 8'($urandom), 1'b0, '0);
    end else begin
      idx = $urandom_range(known_addr.size() - 1);
      depth = (known_len[idx] > ADDR_BITS) ? ADDR_BITS : known_len[idx];
      // bits below the prefix are free to vary
      below = 32'hFFFF_FFFF >> depth;
      a = known_addr[idx] ^ ($urandom & below);
      if (pick < 50) send_route(KIND_INSERT, a, known_len[idx], 8'($urandom), 1'b0, '0);
      else if (pick < 85) send_route(KIND_LOOKUP, a, 6'($urandom), 8'($urandom), 1'b0, '0);
      else send_route(KIND_LOOKUP, $urandom, 6'($urandom), 8'($urandom), 1'b0, '0);
    end
  endtask

  // receiver stall pattern, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i = 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_stall_i = 1'b1;
    end else if (rx_calm_left != 0) begin
      rx_calm_left--;
      out_stall_i = 1'b0;
    end else begin
      rx_pick = $urandom_range(99);
      if (rx_pick < 3) begin
        rx_calm_left = $urandom_range(40, 10);
        out_stall_i = 1'b0;
      end else if (rx_pick < 60) begin
        out_stall_i = 1'b0;
      end else if (rx_pick < 92) begin
        rx_stall_left = $urandom_range(2, 0);
        out_stall_i = 1'b1;
      end else begin
        rx_stall_left = $urandom_range(30, 10);
        out_stall_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result status %0d port %0h with nothing outstanding",
                                  status_o, port_out_o));
      end else begin
        seen_want = pending_answers.pop_front();
        if (status_o !== seen_want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, seen_want.status));
        if (port_out_o !== seen_want.port)
          report_mismatch($sformatf("port_out %0h, expected %0h", port_out_o, seen_want.port));
      end
    end
  end

  initial begin
    plan_row_t   plan[$];
    int unsigned i;
    // kind, address, prefix length, port, fixed answer, status, port out
    plan.push_back({KIND_LOOKUP, 32'h0000_0000, 6'd0,  8'h00, 1'b1, ST_MISS,    8'h00});
    plan.push_back({KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF, 1'b1, ST_MISS,    8'h00});
    // length-0 prefix is the default route on the root
    plan.push_back({KIND_INSERT, 32'h1234_5678, 6'd0,  8'h5A, 1'b1, ST_UPDATED, 8'h00});
    plan.push_back({KIND_LOOKUP, 32'h1234_5678, 6'd0,  8'h00, 1'b1, ST_HIT,     8'h5A});
    plan.push_back({KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF, 1'b1, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00, 1'b1, ST_HIT,     8'hFF});
    plan.push_back({KIND_LOOKUP, 32'hFFFF_FFFE, 6'd0,  8'h00, 1'b1, ST_HIT,     8'h5A});
    // over-long prefix is clamped to the full address
    plan.push_back({KIND_INSERT, 32'h0000_0000, 6'd63, 8'h00, 1'b1, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'h0000_0000, 6'd0,  8'h00, 1'b1, ST_HIT,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'h0000_0001, 6'd0,  8'h00, 1'b1, ST_HIT,     8'h5A});
    plan.push_back({KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hA5, 1'b1, ST_UPDATED, 8'h00});
    plan.push_back({KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00, 1'b1, ST_HIT,     8'hA5});
    plan.push_back({KIND_INSERT, 32'hC0A8_0000, 6'd16, 8'h11, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_INSERT, 32'hC0A8_01FF, 6'd24, 8'h22, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'hC0A8_0105, 6'd0,  8'h00, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'hC0A8_0205, 6'd0,  8'h00, 1'b0, ST_NEW,     8'h00});
    // marks an inner node that already exists unmarked
    plan.push_back({KIND_INSERT, 32'hC0A8_0000, 6'd8,  8'h44, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'hC0FF_0000, 6'd0,  8'h00, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_INSERT, 32'hAAAA_AAAA, 6'd33, 8'hAA, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'hAAAA_AAAA, 6'd21, 8'h3C, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_INSERT, 32'h5555_5555, 6'd31, 8'h55, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'h5555_5554, 6'd0,  8'h00, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'h8000_0000, 6'd0,  8'h00, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_INSERT, 32'h0000_0000, 6'd0,  8'h00, 1'b0, ST_NEW,     8'h00});
    plan.push_back({KIND_LOOKUP, 32'h1234_5678, 6'd0,  8'h00, 1'b0, ST_NEW,     8'h00});

    trie_left[0] = 0;
    trie_right[0] = 0;
    trie_marked[0] = 1'b0;
    trie_port[0] = '0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[k])
      send_route(plan[k].kind, plan[k].addr, plan[k].plen, plan[k].port, plan[k].fixed,
                 plan[k].want);
    wait_drained();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      random_item();
      // long receiver hold-off while the sender keeps offering
      if (i == RANDOM_ITEMS / 2) begin
        hold_req = 1'b1;
        tx_calm_left = 20;
      end
    end
    wait_drained();

    repeat (ADDR_BITS + 20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/btlpm_pkg.sv
rtl/btlpm_ctrl.sv
rtl/btlpm_datapath.sv
rtl/binary_trie_longest_prefix_match_top.sv
rtl/btlpm_checker.sv
tb/binary_trie_longest_prefix_match_top_tb.sv
